@@ src/snfcs_pkg.sv @@
// Shared types, codes and constants of the SPI NOR flash command sequencer.
package snfcs_pkg;

  localparam int unsigned CapacityBytes = 4194304;
  localparam int unsigned PageBytes     = 256;
  localparam int unsigned SectorBytes   = 4096;
  localparam int unsigned BlockBytes    = 65536;
  localparam int unsigned MaxResults    = 8;

  localparam logic [3:0] FuncRead       = 4'd0;
  localparam logic [3:0] FuncFastRead   = 4'd1;
  localparam logic [3:0] FuncProgram    = 4'd2;
  localparam logic [3:0] FuncEraseSect  = 4'd3;
  localparam logic [3:0] FuncEraseBlk   = 4'd4;
  localparam logic [3:0] FuncReadId     = 4'd5;
  localparam logic [3:0] FuncDataByte   = 4'd6;
  localparam logic [3:0] FuncRxByte     = 4'd7;
  localparam logic [3:0] FuncTick       = 4'd8;

  localparam logic [1:0] KindSend    = 2'd0;
  localparam logic [1:0] KindClockIn = 2'd1;
  localparam logic [1:0] KindHost    = 2'd2;
  localparam logic [1:0] KindDone    = 2'd3;

  localparam logic [2:0] StatOk      = 3'd0;
  localparam logic [2:0] StatParam   = 3'd1;
  localparam logic [2:0] StatRange   = 3'd2;
  localparam logic [2:0] StatAlign   = 3'd3;
  localparam logic [2:0] StatTimeout = 3'd4;
  localparam logic [2:0] StatNoWel   = 3'd5;

  localparam logic [7:0] CmdWriteEn   = 8'h06;
  localparam logic [7:0] CmdReadStat  = 8'h05;
  localparam logic [7:0] CmdRead      = 8'h03;
  localparam logic [7:0] CmdFastRead  = 8'h0B;
  localparam logic [7:0] CmdProgram   = 8'h02;
  localparam logic [7:0] CmdSectErase = 8'h20;
  localparam logic [7:0] CmdBlkErase  = 8'hD8;
  localparam logic [7:0] CmdReadId    = 8'h9F;

  localparam logic [1:0] CfgPageTimeout   = 2'd0;
  localparam logic [1:0] CfgSectorTimeout = 2'd1;
  localparam logic [1:0] CfgBlockTimeout  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic       select_held;
    logic [7:0] host_byte;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    logic       load;
    logic [3:0] count;
    result_t [MaxResults-1:0] list;
  } batch_t;

  typedef struct packed {
    logic [15:0] page_ms;
    logic [15:0] sector_ms;
    logic [15:0] block_ms;
  } timeouts_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [7:0] spi, logic held,
                                     logic [7:0] host, logic [2:0] status);
    result_t r;
    r.kind        = kind;
    r.spi_byte    = spi;
    r.select_held = held;
    r.host_byte   = host;
    r.status      = status;
    return r;
  endfunction

endpackage

@@ src/snfcs_core.sv @@
// Sequencer state and the per-beat result computation.
module snfcs_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [3:0]            func_i,
  input  logic [23:0]           address_i,
  input  logic [22:0]           length_i,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            rx_byte_i,
  input  snfcs_pkg::timeouts_t  tmo_i,
  output snfcs_pkg::batch_t     batch_o
);

  typedef enum logic [2:0] {
    PhIdle, PhReadRx, PhWelRx, PhProgData, PhPollRx
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [22:0] left_q, left_d;
  logic [8:0]  page_q, page_d;
  logic [15:0] ms_q, ms_d;

  snfcs_pkg::result_t [snfcs_pkg::MaxResults-1:0] res;
  logic [3:0]  n;
  logic [24:0] end_len, end_sect, end_blk;
  logic [8:0]  room;
  logic [15:0] limit;
  logic [22:0] left_m1;

  localparam logic [24:0] Cap = 25'(snfcs_pkg::CapacityBytes);

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    left_d  = left_q;
    page_d  = page_q;
    ms_d    = ms_q;
    n       = 4'd0;
    res     = '0;
    end_len  = {1'b0, address_i} + {2'b00, length_i};
    end_sect = {1'b0, address_i} + 25'(snfcs_pkg::SectorBytes);
    end_blk  = {1'b0, address_i} + 25'(snfcs_pkg::BlockBytes);
    room     = 9'(snfcs_pkg::PageBytes) - {1'b0, addr_q[7:0]};
    left_m1  = (left_q != 23'd0) ? left_q - 23'd1 : left_q;
    if (op_q == snfcs_pkg::FuncProgram) begin
      limit = tmo_i.page_ms;
    end else if (op_q == snfcs_pkg::FuncEraseSect) begin
      limit = tmo_i.sector_ms;
    end else begin
      limit = tmo_i.block_ms;
    end

    if (accept_i) begin
      if (func_i <= snfcs_pkg::FuncReadId) begin
        if (phase_q == PhIdle) begin
          op_d   = func_i;
          addr_d = address_i;
          if (func_i == snfcs_pkg::FuncReadId) begin
            left_d = 23'd3;
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadId, 1'b1,
                                       8'h00, snfcs_pkg::StatOk);
            res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b1, 8'h00,
                                       snfcs_pkg::StatOk);
            n = 4'd2;
            phase_d = PhReadRx;
          end else if (func_i >= snfcs_pkg::FuncEraseSect) begin
            if ((func_i == snfcs_pkg::FuncEraseSect) ? (address_i[11:0] != 12'd0)
                                                     : (address_i[15:0] != 16'd0)) begin
              res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatAlign);
              n = 4'd1;
            end else if ((func_i == snfcs_pkg::FuncEraseSect) ? (end_sect > Cap)
                                                              : (end_blk > Cap)) begin
              res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatRange);
              n = 4'd1;
            end else begin
              n = 4'd3;
              phase_d = PhWelRx;
            end
          end else if (length_i == 23'd0) begin
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                       snfcs_pkg::StatOk);
            n = 4'd1;
          end else if (end_len > Cap) begin
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                       snfcs_pkg::StatRange);
            n = 4'd1;
          end else if (func_i == snfcs_pkg::FuncProgram) begin
            left_d  = length_i;
            n       = 4'd3;
            phase_d = PhWelRx;
          end else if (length_i > 23'd65535) begin
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                       snfcs_pkg::StatParam);
            n = 4'd1;
          end else begin
            left_d = length_i;
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend,
                                       (func_i == snfcs_pkg::FuncRead) ?
                                       snfcs_pkg::CmdRead : snfcs_pkg::CmdFastRead,
                                       1'b1, 8'h00, snfcs_pkg::StatOk);
            res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, address_i[23:16], 1'b1, 8'h00,
                                       snfcs_pkg::StatOk);
            res[2] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, address_i[15:8], 1'b1, 8'h00,
                                       snfcs_pkg::StatOk);
            res[3] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, address_i[7:0], 1'b1, 8'h00,
                                       snfcs_pkg::StatOk);
            if (func_i == snfcs_pkg::FuncFastRead) begin
              res[4] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, 8'h00, 1'b1, 8'h00,
                                         snfcs_pkg::StatOk);
              res[5] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00,
                                         length_i > 23'd1, 8'h00, snfcs_pkg::StatOk);
              n = 4'd6;
            end else begin
              res[4] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00,
                                         length_i > 23'd1, 8'h00, snfcs_pkg::StatOk);
              n = 4'd5;
            end
            phase_d = PhReadRx;
          end
          // Write-enable then status read opens every program and erase that passes its checks.
          if (phase_d == PhWelRx) begin
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdWriteEn, 1'b0,
                                       8'h00, snfcs_pkg::StatOk);
            res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadStat, 1'b1,
                                       8'h00, snfcs_pkg::StatOk);
            res[2] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b0, 8'h00,
                                       snfcs_pkg::StatOk);
          end
          if (n == 4'd1) begin
            phase_d = PhIdle;
          end
        end
      end else if (func_i == snfcs_pkg::FuncDataByte) begin
        if (phase_q == PhProgData && page_q != 9'd0) begin
          res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, data_byte_i, page_q > 9'd1,
                                     8'h00, snfcs_pkg::StatOk);
          addr_d = addr_q + 24'd1;
          left_d = left_m1;
          page_d = page_q - 9'd1;
          n = 4'd1;
          if (page_q == 9'd1) begin
            ms_d   = 16'd0;
            res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadStat, 1'b1,
                                       8'h00, snfcs_pkg::StatOk);
            res[2] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b0, 8'h00,
                                       snfcs_pkg::StatOk);
            n = 4'd3;
            phase_d = PhPollRx;
          end
        end
      end else if (func_i == snfcs_pkg::FuncRxByte) begin
        unique case (phase_q)
          PhReadRx: begin
            res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindHost, 8'h00, 1'b0, rx_byte_i,
                                       snfcs_pkg::StatOk);
            left_d = left_m1;
            if (left_m1 == 23'd0) begin
              res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatOk);
              phase_d = PhIdle;
            end else begin
              res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, left_m1 > 23'd1,
                                         8'h00, snfcs_pkg::StatOk);
            end
            n = 4'd2;
          end
          PhWelRx: begin
            if (!rx_byte_i[1]) begin
              res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatNoWel);
              n = 4'd1;
              phase_d = PhIdle;
            end else begin
              if (op_q == snfcs_pkg::FuncProgram) begin
                res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdProgram, 1'b1,
                                           8'h00, snfcs_pkg::StatOk);
                page_d = ({9'd0, left_q[13:0]} < {14'd0, room} || left_q[22:14] != 9'd0) ?
                         ((left_q < {14'd0, room}) ? left_q[8:0] : room) : room;
                n = 4'd4;
                phase_d = PhProgData;
              end else begin
                res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend,
                                           (op_q == snfcs_pkg::FuncEraseSect) ?
                                           snfcs_pkg::CmdSectErase : snfcs_pkg::CmdBlkErase,
                                           1'b1, 8'h00, snfcs_pkg::StatOk);
                res[4] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadStat, 1'b1,
                                           8'h00, snfcs_pkg::StatOk);
                res[5] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b0, 8'h00,
                                           snfcs_pkg::StatOk);
                ms_d = 16'd0;
                n = 4'd6;
                phase_d = PhPollRx;
              end
              res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, addr_q[23:16], 1'b1, 8'h00,
                                         snfcs_pkg::StatOk);
              res[2] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, addr_q[15:8], 1'b1, 8'h00,
                                         snfcs_pkg::StatOk);
              res[3] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, addr_q[7:0],
                                         op_q == snfcs_pkg::FuncProgram, 8'h00,
                                         snfcs_pkg::StatOk);
            end
          end
          PhPollRx: begin
            if (!rx_byte_i[0]) begin
              if (op_q == snfcs_pkg::FuncProgram && left_q != 23'd0) begin
                res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdWriteEn, 1'b0,
                                           8'h00, snfcs_pkg::StatOk);
                res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadStat,
                                           1'b1, 8'h00, snfcs_pkg::StatOk);
                res[2] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b0, 8'h00,
                                           snfcs_pkg::StatOk);
                n = 4'd3;
                phase_d = PhWelRx;
              end else begin
                res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                           snfcs_pkg::StatOk);
                n = 4'd1;
                phase_d = PhIdle;
              end
            end else if (ms_q >= limit) begin
              res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindDone, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatTimeout);
              n = 4'd1;
              phase_d = PhIdle;
            end else begin
              res[0] = snfcs_pkg::mk_res(snfcs_pkg::KindSend, snfcs_pkg::CmdReadStat, 1'b1,
                                         8'h00, snfcs_pkg::StatOk);
              res[1] = snfcs_pkg::mk_res(snfcs_pkg::KindClockIn, 8'h00, 1'b0, 8'h00,
                                         snfcs_pkg::StatOk);
              n = 4'd2;
            end
          end
          default: begin
          end
        endcase
      end else if (func_i == snfcs_pkg::FuncTick) begin
        if (phase_q == PhPollRx && ms_q != 16'hFFFF) begin
          ms_d = ms_q + 16'd1;
        end
      end
    end
    batch_o.load  = accept_i;
    batch_o.count = n;
    batch_o.list  = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      op_q    <= 4'd0;
      addr_q  <= 24'd0;
      left_q  <= 23'd0;
      page_q  <= 9'd0;
      ms_q    <= 16'd0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      page_q  <= page_d;
      ms_q    <= ms_d;
    end
  end

endmodule

@@ src/snfcs_outq.sv @@
// Result buffer that hands out one result beat per cycle while out_ready_i is high.
module snfcs_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  snfcs_pkg::batch_t  batch_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output snfcs_pkg::result_t head_o,
  output logic               last_o
);

  snfcs_pkg::result_t [snfcs_pkg::MaxResults-1:0] list_q, list_d;
  logic [3:0] rem_q, rem_d;
  logic       pop;

  assign out_valid_o = (rem_q != 4'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (rem_q == 4'd0) || ((rem_q == 4'd1) && out_ready_i);
  assign head_o      = list_q[0];
  assign last_o      = (rem_q == 4'd1);

  always_comb begin
    list_d = list_q;
    rem_d  = rem_q;
    if (batch_i.load) begin
      list_d = batch_i.list;
      rem_d  = batch_i.count;
    end else if (pop) begin
      list_d = {snfcs_pkg::result_t'('0), list_q[snfcs_pkg::MaxResults-1:1]};
      rem_d  = rem_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 4'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

endmodule

@@ src/spi_nor_flash_command_sequencer_unit.sv @@
// Top level of the SPI NOR flash command sequencer.
// The first result beat of an item appears in the cycle after the item is accepted.
// The input takes one beat per cycle while each item causes at most one result and the
// receiver is ready; an item with more results holds the input until its last is taken.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, empties the
// result buffer and restores the timeouts to 10, 500 and 3000 ms.
module spi_nor_flash_command_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [23:0] address_i,
  input  logic [22:0] length_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  spi_byte_o,
  output logic        select_held_o,
  output logic [7:0]  host_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // The timeout registers are written directly; writes to an unused index are dropped.
  snfcs_pkg::timeouts_t tmo_q, tmo_d;
  snfcs_pkg::batch_t    batch;
  snfcs_pkg::result_t   head;
  logic                 accept;

  always_comb begin
    tmo_d = tmo_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        snfcs_pkg::CfgPageTimeout:   tmo_d.page_ms   = cfg_data_i;
        snfcs_pkg::CfgSectorTimeout: tmo_d.sector_ms = cfg_data_i;
        snfcs_pkg::CfgBlockTimeout:  tmo_d.block_ms  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q.page_ms   <= 16'd10;
      tmo_q.sector_ms <= 16'd500;
      tmo_q.block_ms  <= 16'd3000;
    end else begin
      tmo_q <= tmo_d;
    end
  end

  // An input beat is taken whenever the buffer will be empty by the next edge.
  assign accept = in_valid_i && in_ready_o;

  snfcs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .address_i   (address_i),
    .length_i    (length_i),
    .data_byte_i (data_byte_i),
    .rx_byte_i   (rx_byte_i),
    .tmo_i       (tmo_q),
    .batch_o     (batch)
  );

  snfcs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .last_o      (last_o)
  );

  assign kind_o        = head.kind;
  assign spi_byte_o    = head.spi_byte;
  assign select_held_o = head.select_held;
  assign host_byte_o   = head.host_byte;
  assign status_o      = head.status;

endmodule

@@ src/snfcs_checker.sv @@
// Port-level checker for the sequencer, bound to the top level.
module snfcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [2:0] status_o,
  input logic       last_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(last_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == snfcs_pkg::KindDone |-> last_o)
    else $error("completion beat not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != snfcs_pkg::KindDone |-> status_o == snfcs_pkg::StatOk)
    else $error("status on a non-completion beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind spi_nor_flash_command_sequencer_unit snfcs_checker u_snfcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .status_o    (status_o),
  .last_o      (last_o)
);

@@ dv/testbench.sv @@
// Self-checking testbench of the SPI NOR flash command sequencer top level.
module testbench;
  import snfcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Sequencer phases as tracked by the testbench's own copy of the state.
  typedef enum logic [3:0] {
    PhIdle, PhReadRx, PhWelRx, PhProgData, PhPollRx
  } seq_phase_e;

  // One result beat as it is expected on the output channel.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] spi_byte;
    logic       select_held;
    logic [7:0] host_byte;
    logic [2:0] status;
    logic       last;
  } flash_beat_t;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  func_i;
  logic [23:0] address_i;
  logic [22:0] length_i;
  logic [7:0]  data_byte_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  spi_byte_o;
  logic        select_held_o;
  logic [7:0]  host_byte_o;
  logic [2:0]  status_o;
  logic        last_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  spi_nor_flash_command_sequencer_unit u_top (.*);

  // Expected output beats in order, and the beats of the item being predicted.
  flash_beat_t expected_beats[$];
  flash_beat_t item_beats[$];

  // The testbench's own copy of the sequencer state and of the timeouts.
  seq_phase_e  mdl_phase;
  int unsigned mdl_op;
  int unsigned mdl_addr;
  int unsigned mdl_left;
  int unsigned mdl_page_left;
  int unsigned mdl_elapsed;
  int unsigned mdl_page_ms;
  int unsigned mdl_sector_ms;
  int unsigned mdl_block_ms;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned out_gap = 0;
  int unsigned rx_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. Each call appends one beat to the beats of the current item.
  // ---------------------------------------------------------------------------
  function automatic void put_beat(logic [1:0] k, logic [7:0] s, logic h,
                                   logic [7:0] hb, logic [2:0] st);
    flash_beat_t b;
    b.kind = k;
    b.spi_byte = s;
    b.select_held = h;
    b.host_byte = hb;
    b.status = st;
    b.last = 1'b0;
    item_beats.push_back(b);
  endfunction

  function automatic void complete(logic [2:0] st);
    mdl_phase = PhIdle;
    put_beat(KindDone, 8'h00, 1'b0, 8'h00, st);
  endfunction

  // The three address bytes, most significant first.
  function automatic void put_address(int unsigned a, logic held_after);
    put_beat(KindSend, a[23:16], 1'b1, 8'h00, StatOk);
    put_beat(KindSend, a[15:8], 1'b1, 8'h00, StatOk);
    put_beat(KindSend, a[7:0], held_after, 8'h00, StatOk);
  endfunction

  // Write enable, then a status read to confirm that the latch took.
  function automatic void begin_write_enable();
    put_beat(KindSend, CmdWriteEn, 1'b0, 8'h00, StatOk);
    put_beat(KindSend, CmdReadStat, 1'b1, 8'h00, StatOk);
    put_beat(KindClockIn, 8'h00, 1'b0, 8'h00, StatOk);
    mdl_phase = PhWelRx;
  endfunction

  function automatic void begin_busy_poll();
    mdl_elapsed = 0;
    put_beat(KindSend, CmdReadStat, 1'b1, 8'h00, StatOk);
    put_beat(KindClockIn, 8'h00, 1'b0, 8'h00, StatOk);
    mdl_phase = PhPollRx;
  endfunction

  function automatic bit beyond_capacity(int unsigned a, int unsigned len);
    return (a >= CapacityBytes) || (len > CapacityBytes - a);
  endfunction

  function automatic void take_request(int unsigned f, int unsigned a, int unsigned len);
    int unsigned span;
    mdl_op = f;
    mdl_addr = a;
    if (f == FuncRead || f == FuncFastRead) begin
      if (len == 0) complete(StatOk);
      else if (beyond_capacity(a, len)) complete(StatRange);
      else if (len > 65535) complete(StatParam);
      else begin
        mdl_left = len;
        put_beat(KindSend, (f == FuncRead) ? CmdRead : CmdFastRead, 1'b1, 8'h00, StatOk);
        put_address(a, 1'b1);
        // Fast read clocks one dummy byte before the data.
        if (f == FuncFastRead) put_beat(KindSend, 8'h00, 1'b1, 8'h00, StatOk);
        put_beat(KindClockIn, 8'h00, len > 1, 8'h00, StatOk);
        mdl_phase = PhReadRx;
      end
    end else if (f == FuncProgram) begin
      if (len == 0) complete(StatOk);
      else if (beyond_capacity(a, len)) complete(StatRange);
      else begin
        mdl_left = len;
        begin_write_enable();
      end
    end else if (f == FuncEraseSect || f == FuncEraseBlk) begin
      span = (f == FuncEraseSect) ? SectorBytes : BlockBytes;
      if ((a % span) != 0) complete(StatAlign);
      else if (beyond_capacity(a, span)) complete(StatRange);
      else begin_write_enable();
    end else begin
      mdl_left = 3;
      put_beat(KindSend, CmdReadId, 1'b1, 8'h00, StatOk);
      put_beat(KindClockIn, 8'h00, 1'b1, 8'h00, StatOk);
      mdl_phase = PhReadRx;
    end
  endfunction

  function automatic void take_rx(logic [7:0] rx);
    int unsigned room;
    int unsigned limit;
    case (mdl_phase)
      PhReadRx: begin
        put_beat(KindHost, 8'h00, 1'b0, rx, StatOk);
        if (mdl_left > 0) mdl_left--;
        if (mdl_left == 0) complete(StatOk);
        else put_beat(KindClockIn, 8'h00, mdl_left > 1, 8'h00, StatOk);
      end
      PhWelRx: begin
        if (!rx[1]) complete(StatNoWel);
        else if (mdl_op == FuncProgram) begin
          // A page program never crosses a page boundary.
          room = PageBytes - (mdl_addr % PageBytes);
          mdl_page_left = (mdl_left < room) ? mdl_left : room;
          put_beat(KindSend, CmdProgram, 1'b1, 8'h00, StatOk);
          put_address(mdl_addr, 1'b1);
          mdl_phase = PhProgData;
        end else begin
          put_beat(KindSend, (mdl_op == FuncEraseSect) ? CmdSectErase : CmdBlkErase,
                   1'b1, 8'h00, StatOk);
          put_address(mdl_addr, 1'b0);
          begin_busy_poll();
        end
      end
      PhPollRx: begin
        if (!rx[0]) begin
          if (mdl_op == FuncProgram && mdl_left > 0) begin_write_enable();
          else complete(StatOk);
        end else begin
          limit = (mdl_op == FuncProgram) ? mdl_page_ms :
                  (mdl_op == FuncEraseSect) ? mdl_sector_ms : mdl_block_ms;
          if (mdl_elapsed >= limit) complete(StatTimeout);
          else begin
            put_beat(KindSend, CmdReadStat, 1'b1, 8'h00, StatOk);
            put_beat(KindClockIn, 8'h00, 1'b0, 8'h00, StatOk);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_data(logic [7:0] d);
    if (mdl_phase == PhProgData && mdl_page_left != 0) begin
      put_beat(KindSend, d, mdl_page_left > 1, 8'h00, StatOk);
      mdl_addr = (mdl_addr + 1) & 24'hFFFFFF;
      if (mdl_left > 0) mdl_left--;
      mdl_page_left--;
      if (mdl_page_left == 0) begin_busy_poll();
    end
  endfunction

  // Works out the beats caused by one item and queues them; returns their count.
  function automatic int unsigned predict_beats(logic [3:0] f, logic [23:0] a,
                                                logic [22:0] len, logic [7:0] d,
                                                logic [7:0] rx);
    int unsigned n;
    item_beats.delete();
    if (f <= FuncReadId) begin
      if (mdl_phase == PhIdle) take_request(f, a, len);
    end else if (f == FuncDataByte) take_data(d);
    else if (f == FuncRxByte) take_rx(rx);
    else if (f == FuncTick) begin
      if (mdl_phase == PhPollRx && mdl_elapsed < 65535) mdl_elapsed++;
    end
    n = item_beats.size();
    if (n > 0) item_beats[n-1].last = 1'b1;
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking.
  // ---------------------------------------------------------------------------

  // Sends one input beat. The predictor runs first, since an offered beat is
  // always accepted in the end and the state must follow acceptance order.
  task automatic send_item(input logic [3:0] f, input logic [23:0] a,
                           input logic [22:0] len, input logic [7:0] d,
                           input logic [7:0] rx, output int unsigned n);
    int unsigned gap;
    n = predict_beats(f, a, len, d, rx);
    gap = idle_en ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i = f;
    address_i = a;
    length_i = len;
    data_byte_i = d;
    rx_byte_i = rx;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send(input logic [3:0] f, input logic [23:0] a, input logic [22:0] len,
                      input logic [7:0] d, input logic [7:0] rx);
    int unsigned n;
    send_item(f, a, len, d, rx, n);
  endtask

  // Lets the block go quiet: all expected beats seen, then a drain with the input idle.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgPageTimeout:   mdl_page_ms = value;
      CfgSectorTimeout: mdl_sector_ms = value;
      CfgBlockTimeout:  mdl_block_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_timeouts(input logic [15:0] pg, input logic [15:0] sc,
                              input logic [15:0] bk);
    settle();
    write_timeout(CfgPageTimeout, pg);
    write_timeout(CfgSectorTimeout, sc);
    write_timeout(CfgBlockTimeout, bk);
  endtask

  // Output ready: a long hold-off when asked, otherwise the drawn gap.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else if (out_gap > 0) begin
        out_ready_i = 1'b0;
        out_gap--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Every accepted output beat is compared with the oldest expected one.
  initial begin
    flash_beat_t got;
    flash_beat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = {kind_o, spi_byte_o, select_held_o, host_byte_o, status_o, last_o};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat kind=%0d spi=%h held=%b host=%h st=%0d last=%b",
                     got.kind, got.spi_byte, got.select_held, got.host_byte,
                     got.status, got.last);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"beat mismatch exp kind=%0d spi=%h held=%b host=%h st=%0d last=%b",
                        " got kind=%0d spi=%h held=%b host=%h st=%0d last=%b"},
                       want.kind, want.spi_byte, want.select_held, want.host_byte,
                       want.status, want.last, got.kind, got.spi_byte,
                       got.select_held, got.host_byte, got.status, got.last);
          end
        end
        out_gap = idle_en ? $urandom_range(0, 8) : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Picks the next item from the tracked phase, so that most of the traffic is
  // a sensible flash conversation with random content and some is noise.
  task automatic pick_item(output logic [3:0] f, output logic [23:0] a,
                           output logic [22:0] len, output logic [7:0] d,
                           output logic [7:0] rx);
    f = FuncTick;
    a = $urandom();
    len = $urandom();
    d = $urandom();
    rx = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      f = $urandom();
      if ($urandom_range(0, 1)) len = $urandom_range(0, 8);
    end else begin
      case (mdl_phase)
        PhIdle: begin
          f = $urandom_range(FuncRead, FuncReadId);
          if ($urandom_range(0, 5) != 0) begin
            a = $urandom_range(0, CapacityBytes - 1);
            len = $urandom_range(1, 6);
            // Near the end of a page, so that programs get split.
            if ($urandom_range(0, 1)) a[7:0] = 8'hFF - $urandom_range(0, 3);
            if (f == FuncEraseSect) a = a & ~(SectorBytes - 1);
            if (f == FuncEraseBlk) a = a & ~(BlockBytes - 1);
          end
        end
        PhReadRx: f = FuncRxByte;
        PhWelRx: begin
          f = FuncRxByte;
          if ($urandom_range(0, 9) != 0) rx[1] = 1'b1;
        end
        PhProgData: f = FuncDataByte;
        default: begin
          f = ($urandom_range(0, 9) < 4) ? FuncTick : FuncRxByte;
          rx[0] = ($urandom_range(0, 9) < 6);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    // A zero-length read, then range and over-long read errors.
    send(FuncRead, 24'h000000, 23'd0, 8'h00, 8'h00);
    send(FuncRead, 24'hFFFFFF, 23'h7FFFFF, 8'hFF, 8'hFF);
    send(FuncFastRead, 24'h3FFFFF, 23'd2, 8'h00, 8'h00);
    send(FuncRead, 24'h000000, 23'd65536, 8'h00, 8'h00);
    // Single byte read, then a two byte fast read at the top of the device.
    send(FuncRead, 24'h123456, 23'd1, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'hFF);
    send(FuncFastRead, 24'h3FFFFE, 23'd2, 8'h00, 8'h00);
    // A request while a read is in progress is dropped.
    send(FuncReadId, 24'h0, 23'd0, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'hA5);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h5A);
    // Tick, stray data and an unknown code while idle: no beats.
    send(FuncTick, 24'h0, 23'd0, 8'h00, 8'h00);
    send(FuncDataByte, 24'h0, 23'd0, 8'hFF, 8'h00);
    send(4'hF, 24'hFFFFFF, 23'h7FFFFF, 8'hFF, 8'hFF);
    // Erase alignment and range errors, then an erase whose write enable fails.
    send(FuncEraseSect, 24'h000800, 23'd0, 8'h00, 8'h00);
    send(FuncEraseBlk, 24'h400000, 23'd0, 8'h00, 8'h00);
    send(FuncEraseSect, 24'h001000, 23'd0, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h00);
    // A program that crosses a page boundary, with one busy poll in between.
    send(FuncProgram, 24'h0000FF, 23'd2, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h02);
    send(FuncDataByte, 24'h0, 23'd0, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h01);
    send(FuncTick, 24'h0, 23'd0, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'h03);
    send(FuncDataByte, 24'h0, 23'd0, 8'hC3, 8'h00);
    send(FuncRxByte, 24'h0, 23'd0, 8'h00, 8'hFE);
  endtask

  // Random traffic until the given number of items have caused beats.
  task automatic test_random(input int unsigned items);
    logic [3:0]  f;
    logic [23:0] a;
    logic [22:0] len;
    logic [7:0]  d;
    logic [7:0]  rx;
    int unsigned n;
    int unsigned done_items;
    done_items = 0;
    while (done_items < items) begin
      // Alternate stretches with and without idle cycles.
      if ((done_items % 20) == 0) idle_en = ($urandom_range(0, 2) != 0);
      pick_item(f, a, len, d, rx);
      send_item(f, a, len, d, rx, n);
      if (n > 0) done_items++;
    end
    idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    rx_hold = 300;
    test_random(25);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = '0;
    address_i = '0;
    length_i = '0;
    data_byte_i = '0;
    rx_byte_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    mdl_phase = PhIdle;
    mdl_op = 0;
    mdl_addr = 0;
    mdl_left = 0;
    mdl_page_left = 0;
    mdl_elapsed = 0;
    mdl_page_ms = 10;
    mdl_sector_ms = 500;
    mdl_block_ms = 3000;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    // Short timeouts, so that busy polling runs out.
    set_timeouts(16'd1, 16'd1, 16'd1);
    test_random(35);
    set_timeouts(16'd3, 16'd5, 16'd2);
    test_random(35);
    test_backpressure();
    // Longest timeouts, then back to the reset values.
    set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
    test_random(30);
    set_timeouts(16'd10, 16'd500, 16'd3000);
    test_random(30);
    settle();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ spi_nor_flash_command_sequencer_unit.f @@
src/snfcs_pkg.sv
src/snfcs_core.sv
src/snfcs_outq.sv
src/spi_nor_flash_command_sequencer_unit.sv
src/snfcs_checker.sv
dv/testbench.sv
